FILE: design/word_run_and_backref_decompressor_assert.svh
// Assertion macros for the decompressor RTL.
// Depends on nothing; included by wrbd_back, the module that carries assertions.
`ifndef WORD_RUN_AND_BACKREF_DECOMPRESSOR_ASSERT_SVH
`define WORD_RUN_AND_BACKREF_DECOMPRESSOR_ASSERT_SVH

// same-cycle implication, disabled in reset
`define WRBD_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled in reset
`define WRBD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: design/wrbd_pkg.sv
// Package for the word run and back-reference decompressor.
// Holds widths, opcodes, mode and status codes, and the queue word types.
package wrbd_pkg;

    localparam int HIST_DEPTH  = 4096;
    localparam int WORD_W      = 32;
    localparam int OPC_W       = 8;
    localparam int COUNT_W     = 24;
    localparam int PASS_W      = 8;
    localparam int CHUNK_W     = 16;
    localparam int SHORT_W     = 12;
    localparam int OFF_W       = 16;
    localparam int PIX_W       = 25;
    localparam int LEN_CMP_W   = CHUNK_W + 1;
    localparam int QUEUE_DEPTH = 4;

    localparam logic [OPC_W-1:0] OPC_LIT   = 8'd1;
    localparam logic [OPC_W-1:0] OPC_FILL  = 8'd2;
    localparam logic [OPC_W-1:0] OPC_CHUNK = 8'd3;
    localparam logic [OPC_W-1:0] OPC_COPY  = 8'd4;

    typedef enum logic [2:0] {
        OP_NONE,
        OP_LIT,
        OP_FILL,
        OP_CHUNK,
        OP_COPY
    } t_op;

    typedef enum logic [2:0] {
        M_IDLE,
        M_LIT,
        M_FILLWAIT,
        M_FILL,
        M_CHUNK,
        M_COPY,
        M_SKIP
    } t_mode;

    typedef enum logic [1:0] {
        ST_OK,
        ST_KIND,
        ST_OFFSET,
        ST_CHUNK
    } t_status;

    typedef struct packed {
        logic               is_tick;
        logic [WORD_W-1:0]  word;
        t_op                op;
        logic [COUNT_W-1:0] replay;
        logic               too_long;
    } t_item;

    typedef struct packed {
        logic              pixel_valid;
        logic [WORD_W-1:0] pixel;
        logic              need_word;
        logic              frame_done;
        t_status           status;
    } t_result;

endpackage

FILE: design/wrbd_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Used for the pixel history; no package dependency.
module wrbd_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: design/wrbd_fifo.sv
// Small register FIFO with push/full and pop/empty sides.
// Generic; used for the input queue and the result queue.
module wrbd_fifo #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 4
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_wdata,
    output logic             o_full,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_rdata,
    output logic             o_empty
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = AW + 1;

    logic [WIDTH-1:0] r_data [DEPTH];
    logic [AW-1:0]    r_wr_ptr, n_wr_ptr;
    logic [AW-1:0]    r_rd_ptr, n_rd_ptr;
    logic [CW-1:0]    r_count, n_count;
    logic             do_push;
    logic             do_pop;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_empty = (r_count == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_rdata = r_data[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (do_push) begin
            n_wr_ptr = (r_wr_ptr == AW'(DEPTH - 1)) ? '0 : r_wr_ptr + AW'(1);
        end
        if (do_pop) begin
            n_rd_ptr = (r_rd_ptr == AW'(DEPTH - 1)) ? '0 : r_rd_ptr + AW'(1);
        end
        if (do_push && !do_pop) begin
            n_count = r_count + CW'(1);
        end else if (do_pop && !do_push) begin
            n_count = r_count - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_data[r_wr_ptr] <= i_wdata;
        end
    end

endmodule

FILE: design/wrbd_front.sv
// Front end: decodes incoming words and ticks and queues them for execution.
// Depends on wrbd_pkg and wrbd_fifo.
module wrbd_front #(
    parameter int HISTORY_DEPTH = wrbd_pkg::HIST_DEPTH
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_push,
    output logic                         o_full,
    input  logic                         i_req_type,
    input  logic [wrbd_pkg::WORD_W-1:0]  i_stream_word,
    input  logic                         i_pop,
    output wrbd_pkg::t_item              o_item,
    output logic                         o_empty
);

    import wrbd_pkg::*;

    t_item                    dec;
    logic [OPC_W-1:0]         opc;
    logic [CHUNK_W-1:0]       chunk;
    logic [PASS_W-1:0]        passes;
    logic [COUNT_W-1:0]       prod;
    logic [$bits(t_item)-1:0] q_rdata;

    assign opc    = i_stream_word[OPC_W-1:0];
    assign passes = i_stream_word[OPC_W+PASS_W-1:OPC_W];
    assign chunk  = i_stream_word[WORD_W-1:WORD_W-CHUNK_W];
    assign prod   = COUNT_W'(passes - PASS_W'(1)) * COUNT_W'(chunk);

    always_comb begin
        dec.is_tick  = i_req_type;
        dec.word     = i_stream_word;
        dec.replay   = prod;
        dec.too_long = (passes >= PASS_W'(2))
                       && (LEN_CMP_W'(chunk) > LEN_CMP_W'(HISTORY_DEPTH));
        case (opc)
            OPC_LIT:   dec.op = OP_LIT;
            OPC_FILL:  dec.op = OP_FILL;
            OPC_CHUNK: dec.op = OP_CHUNK;
            OPC_COPY:  dec.op = OP_COPY;
            default:   dec.op = OP_NONE;
        endcase
    end

    wrbd_fifo #(
        .WIDTH ($bits(t_item)),
        .DEPTH (QUEUE_DEPTH)
    ) u_in_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (i_push),
        .i_wdata (dec),
        .o_full  (o_full),
        .i_pop   (i_pop),
        .o_rdata (q_rdata),
        .o_empty (o_empty)
    );

    assign o_item = t_item'(q_rdata);

endmodule

FILE: design/wrbd_back.sv
// Back end: run/copy state machine, pixel history and result stage.
// Depends on wrbd_pkg, wrbd_ram and the assertion macro header.
`include "word_run_and_backref_decompressor_assert.svh"

module wrbd_back #(
    parameter int HISTORY_DEPTH = wrbd_pkg::HIST_DEPTH
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [wrbd_pkg::PIX_W-1:0]  i_cfg_total,
    input  wrbd_pkg::t_item             i_item,
    input  logic                        i_item_valid,
    output logic                        o_item_pop,
    output wrbd_pkg::t_result           o_res,
    output logic                        o_res_valid,
    input  logic                        i_res_ready
);

    import wrbd_pkg::*;

    localparam int AW     = $clog2(HISTORY_DEPTH);
    localparam int DIFF_W = OFF_W + 1;

    t_mode              r_mode, n_mode;
    logic [COUNT_W-1:0] r_run_left, n_run_left;
    logic [COUNT_W-1:0] r_replay, n_replay;
    logic [PASS_W-1:0]  r_passes, n_passes;
    logic [CHUNK_W-1:0] r_chunk, n_chunk;
    logic [OFF_W-1:0]   r_back_off, n_back_off;
    logic [WORD_W-1:0]  r_fill, n_fill;
    logic [AW-1:0]      r_ptr, n_ptr;
    logic [PIX_W-1:0]   r_pix_out, n_pix_out;
    logic [PIX_W-1:0]   r_total;

    logic               r_b_valid;
    logic               r_b_emit;
    logic               r_b_copy;
    logic               r_b_fwd;
    logic [WORD_W-1:0]  r_b_fwd_data;
    logic [WORD_W-1:0]  r_b_px;
    logic [AW-1:0]      r_b_waddr;
    logic               r_b_need;
    logic               r_b_done;
    t_status            r_b_status;

    logic               adv;
    logic               a_fire;
    logic               done;
    logic               wants;
    logic               kind_err;
    logic               live;
    logic               a_emit;
    logic               a_copy;
    logic [WORD_W-1:0]  a_px;
    t_status            a_status;
    logic               a_need;
    logic               a_done;
    logic [COUNT_W-1:0] w_count;
    logic [CHUNK_W-1:0] w_chunk;
    logic [PASS_W-1:0]  w_passes;
    logic [SHORT_W-1:0] w_off;
    logic [SHORT_W-1:0] w_n;
    logic               off_bad;
    logic [COUNT_W-1:0] run_dec;
    logic               run_last;
    logic [DIFF_W-1:0]  diff;
    logic [AW-1:0]      raddr;
    logic               ram_re;
    logic               ram_we;
    logic [WORD_W-1:0]  ram_rdata;
    logic [WORD_W-1:0]  b_px;
    logic               a_fwd;

    assign adv        = !r_b_valid || i_res_ready;
    assign a_fire     = i_item_valid && adv;
    assign o_item_pop = a_fire;

    assign w_count  = i_item.word[WORD_W-1:OPC_W];
    assign w_chunk  = i_item.word[WORD_W-1:WORD_W-CHUNK_W];
    assign w_passes = i_item.word[OPC_W+PASS_W-1:OPC_W];
    assign w_off    = i_item.word[OPC_W+SHORT_W-1:OPC_W];
    assign w_n      = i_item.word[WORD_W-1:WORD_W-SHORT_W];
    assign off_bad  = (w_off == '0) || (PIX_W'(w_off) > r_pix_out);
    assign run_dec  = r_run_left - COUNT_W'(1);
    assign run_last = (r_run_left == COUNT_W'(1));

    assign done     = (r_pix_out >= r_total);
    assign wants    = !(r_mode == M_FILL || r_mode == M_COPY);
    assign kind_err = !done && (i_item.is_tick == wants);
    assign live     = !done && !kind_err;

    // next state
    always_comb begin
        n_mode     = r_mode;
        n_run_left = r_run_left;
        n_replay   = r_replay;
        n_passes   = r_passes;
        n_chunk    = r_chunk;
        n_back_off = r_back_off;
        n_fill     = r_fill;
        n_ptr      = r_ptr;
        n_pix_out  = r_pix_out;
        if (a_emit) begin
            n_ptr     = (r_ptr == AW'(HISTORY_DEPTH - 1)) ? '0 : r_ptr + AW'(1);
            n_pix_out = r_pix_out + PIX_W'(1);
        end
        if (live) begin
            case (r_mode)
                M_IDLE: begin
                    case (i_item.op)
                        OP_LIT: begin
                            n_run_left = w_count;
                            n_mode     = (w_count != '0) ? M_LIT : M_IDLE;
                        end
                        OP_FILL: begin
                            n_run_left = w_count;
                            n_mode     = M_FILLWAIT;
                        end
                        OP_CHUNK: begin
                            n_chunk    = w_chunk;
                            n_passes   = w_passes;
                            n_run_left = COUNT_W'(w_chunk);
                            n_replay   = i_item.replay;
                            if (w_chunk == '0) begin
                                n_mode = M_IDLE;
                            end else if (i_item.too_long || w_passes == '0) begin
                                n_mode = M_SKIP;
                            end else begin
                                n_mode = M_CHUNK;
                            end
                        end
                        OP_COPY: begin
                            if (!off_bad && w_n != '0) begin
                                n_back_off = OFF_W'(w_off);
                                n_run_left = COUNT_W'(w_n);
                                n_mode     = M_COPY;
                            end
                        end
                        default: n_mode = M_IDLE;
                    endcase
                end
                M_LIT, M_FILL, M_COPY: begin
                    n_run_left = run_dec;
                    if (run_last) begin
                        n_mode = M_IDLE;
                    end
                end
                M_FILLWAIT: begin
                    n_fill = i_item.word;
                    n_mode = (r_run_left != '0) ? M_FILL : M_IDLE;
                end
                M_CHUNK: begin
                    n_run_left = run_dec;
                    if (run_last) begin
                        if (r_passes >= PASS_W'(2)) begin
                            n_back_off = OFF_W'(r_chunk);
                            n_run_left = r_replay;
                            n_mode     = M_COPY;
                        end else begin
                            n_mode = M_IDLE;
                        end
                    end
                end
                M_SKIP: begin
                    if (r_run_left != '0) begin
                        n_run_left = run_dec;
                    end
                    if (r_run_left <= COUNT_W'(1)) begin
                        n_mode = M_IDLE;
                    end
                end
                default: n_mode = M_IDLE;
            endcase
        end
    end

    // outputs of the execute step
    always_comb begin
        a_emit   = live && (r_mode inside {M_LIT, M_FILL, M_CHUNK, M_COPY});
        a_copy   = live && (r_mode == M_COPY);
        a_px     = (r_mode == M_FILL) ? r_fill : i_item.word;
        a_status = ST_OK;
        if (kind_err) begin
            a_status = ST_KIND;
        end else if (live && r_mode == M_IDLE) begin
            if (i_item.op == OP_CHUNK && i_item.too_long) begin
                a_status = ST_CHUNK;
            end else if (i_item.op == OP_COPY && off_bad) begin
                a_status = ST_OFFSET;
            end
        end
        a_done = (n_pix_out >= r_total);
        a_need = a_done || !(n_mode == M_FILL || n_mode == M_COPY);
    end

    // history read address: ptr - offset, wrapped into the ring
    assign diff  = DIFF_W'(r_ptr) - DIFF_W'(r_back_off);
    assign raddr = diff[DIFF_W-1] ? AW'(diff + DIFF_W'(HISTORY_DEPTH)) : AW'(diff);

    assign ram_re = a_fire && a_copy;
    assign a_fwd  = a_copy && r_b_valid && r_b_emit && (raddr == r_b_waddr);
    assign b_px   = r_b_copy ? (r_b_fwd ? r_b_fwd_data : ram_rdata) : r_b_px;
    assign ram_we = r_b_valid && i_res_ready && r_b_emit;

    wrbd_ram #(
        .WIDTH (WORD_W),
        .DEPTH (HISTORY_DEPTH)
    ) u_hist (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_b_waddr),
        .i_wdata (b_px),
        .i_re    (ram_re),
        .i_raddr (raddr),
        .o_rdata (ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode     <= M_IDLE;
            r_run_left <= '0;
            r_replay   <= '0;
            r_passes   <= '0;
            r_chunk    <= '0;
            r_back_off <= '0;
            r_fill     <= '0;
            r_ptr      <= '0;
            r_pix_out  <= '0;
        end else if (a_fire) begin
            r_mode     <= n_mode;
            r_run_left <= n_run_left;
            r_replay   <= n_replay;
            r_passes   <= n_passes;
            r_chunk    <= n_chunk;
            r_back_off <= n_back_off;
            r_fill     <= n_fill;
            r_ptr      <= n_ptr;
            r_pix_out  <= n_pix_out;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_total <= '0;
        end else if (i_cfg_we) begin
            r_total <= i_cfg_total;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
        end else if (adv) begin
            r_b_valid <= a_fire;
        end
    end

    always_ff @(posedge i_clk) begin
        if (a_fire) begin
            r_b_emit     <= a_emit;
            r_b_copy     <= a_copy;
            r_b_fwd      <= a_fwd;
            r_b_fwd_data <= b_px;
            r_b_px       <= a_px;
            r_b_waddr    <= r_ptr;
            r_b_need     <= a_need;
            r_b_done     <= a_done;
            r_b_status   <= a_status;
        end
    end

    always_comb begin
        o_res.pixel_valid = r_b_emit;
        o_res.pixel       = r_b_emit ? b_px : '0;
        o_res.need_word   = r_b_need;
        o_res.frame_done  = r_b_done;
        o_res.status      = r_b_status;
    end

    assign o_res_valid = r_b_valid;

    `WRBD_ASSERT_IMPLY(a_run_nonzero, i_clk, i_rst_n,
        (r_mode == M_LIT || r_mode == M_FILL || r_mode == M_CHUNK || r_mode == M_COPY),
        r_run_left != '0, "active run with zero count")
    `WRBD_ASSERT_NEXT(a_read_feeds_copy, i_clk, i_rst_n, ram_re,
        r_b_valid && r_b_copy && r_b_emit, "history read without copy result")
    `WRBD_ASSERT_NEXT(a_result_holds, i_clk, i_rst_n, r_b_valid && !i_res_ready,
        r_b_valid && $stable(r_b_waddr) && $stable(ram_rdata), "stalled result lost")
    `WRBD_ASSERT_IMPLY(a_fwd_only_copy, i_clk, i_rst_n, r_b_valid && r_b_fwd,
        r_b_copy, "forward flag on non-copy result")

endmodule

FILE: design/word_run_and_backref_decompressor.sv
// Path: an item is taken from the input queue by the execute step, held in the
// result register and then pushed into the result queue. Throughput: one item
// per cycle, one result per item, while the result queue has room.
// Reset: synchronous, active low; clears queues, run state, counters and
// total_pixels. History contents are not cleared.
module word_run_and_backref_decompressor #(
    parameter int HISTORY_DEPTH = wrbd_pkg::HIST_DEPTH
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        push,
    output logic                        full,
    input  logic                        i_req_type,
    input  logic [wrbd_pkg::WORD_W-1:0] i_stream_word,
    output logic                        empty,
    input  logic                        pop,
    output logic                        o_pixel_valid,
    output logic [wrbd_pkg::WORD_W-1:0] o_pixel,
    output logic                        o_need_word,
    output logic                        o_frame_done,
    output logic [1:0]                  o_status,
    input  logic                        i_total_pixels_we,
    input  logic [wrbd_pkg::PIX_W-1:0]  i_total_pixels
);

    import wrbd_pkg::*;

    t_item                      item;
    logic                       item_empty;
    logic                       item_pop;
    t_result                    res;
    logic                       res_valid;
    logic                       out_full;
    t_result                    out_res;
    logic [$bits(t_result)-1:0] out_rdata;

    wrbd_front #(
        .HISTORY_DEPTH (HISTORY_DEPTH)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_push        (push),
        .o_full        (full),
        .i_req_type    (i_req_type),
        .i_stream_word (i_stream_word),
        .i_pop         (item_pop),
        .o_item        (item),
        .o_empty       (item_empty)
    );

    wrbd_back #(
        .HISTORY_DEPTH (HISTORY_DEPTH)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_total_pixels_we),
        .i_cfg_total  (i_total_pixels),
        .i_item       (item),
        .i_item_valid (!item_empty),
        .o_item_pop   (item_pop),
        .o_res        (res),
        .o_res_valid  (res_valid),
        .i_res_ready  (!out_full)
    );

    wrbd_fifo #(
        .WIDTH ($bits(t_result)),
        .DEPTH (QUEUE_DEPTH)
    ) u_out_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_valid),
        .i_wdata (res),
        .o_full  (out_full),
        .i_pop   (pop),
        .o_rdata (out_rdata),
        .o_empty (empty)
    );

    assign out_res       = t_result'(out_rdata);
    assign o_pixel_valid = out_res.pixel_valid;
    assign o_pixel       = out_res.pixel;
    assign o_need_word   = out_res.need_word;
    assign o_frame_done  = out_res.frame_done;
    assign o_status      = out_res.status;

endmodule

FILE: sim/wrbd_pixel_checker.sv
`timescale 1ns / 1ps
// Scoreboard for the word run and back-reference decompressor: keeps its own copy of
// the decode state and history, predicts one result word per accepted input word and
// compares every popped result with the oldest prediction. Depends on wrbd_pkg.
module wrbd_pixel_checker (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_push,
    input  logic                        i_full,
    input  logic                        i_req_type,
    input  logic [wrbd_pkg::WORD_W-1:0] i_stream_word,
    input  logic                        i_empty,
    input  logic                        i_pop,
    input  logic                        i_pixel_valid,
    input  logic [wrbd_pkg::WORD_W-1:0] i_pixel,
    input  logic                        i_need_word,
    input  logic                        i_frame_done,
    input  logic [1:0]                  i_status,
    input  logic                        i_total_pixels_we,
    input  logic [wrbd_pkg::PIX_W-1:0]  i_total_pixels,
    output int                          o_errors,
    output int                          o_pending,
    output logic [wrbd_pkg::PIX_W-1:0]  o_pixels_out,
    output int                          o_checked,
    output int                          o_pixels_seen,
    output int                          o_flagged
);
    import wrbd_pkg::*;

    localparam int HIST_AW = $clog2(HIST_DEPTH);

    t_mode               mode;
    logic [COUNT_W-1:0]  run_left;
    logic [PASS_W-1:0]   passes;
    logic [CHUNK_W-1:0]  chunk_len;
    logic [HIST_AW-1:0]  back_off;
    logic [WORD_W-1:0]   fill_word;
    logic [WORD_W-1:0]   history [HIST_DEPTH];
    logic [HIST_AW-1:0]  hist_ptr;
    logic [PIX_W-1:0]    pix_out;
    logic [PIX_W-1:0]    frame_size;
    t_result             pixel_words_due[$];
    t_result             want;
    t_result             got;

    function automatic logic frame_full();
        return pix_out >= frame_size;
    endfunction

    function automatic logic wants_word(input t_mode m);
        return !(m == M_FILL || m == M_COPY);
    endfunction

    function automatic logic put_pixel(input logic [WORD_W-1:0] px);
        if (frame_full())
            return 1'b0;
        history[hist_ptr] = px;
        hist_ptr = hist_ptr + 1'b1;
        pix_out = pix_out + 1'b1;
        return 1'b1;
    endfunction

    function automatic t_result decompress_step(input logic tick, input logic [WORD_W-1:0] w);
        t_result            r;
        t_status            st;
        logic               valid;
        logic [WORD_W-1:0]  px;
        logic [HIST_AW-1:0] idx;
        st    = ST_OK;
        valid = 1'b0;
        px    = '0;
        if (!frame_full()) begin
            if (tick == wants_word(mode)) begin
                st = ST_KIND;
            end else begin
                case (mode)
                    M_IDLE: begin
                        case (w[7:0])
                            OPC_LIT: begin
                                run_left = w[31:8];
                                if (run_left != 0)
                                    mode = M_LIT;
                            end
                            OPC_FILL: begin
                                run_left = w[31:8];
                                mode = M_FILLWAIT;
                            end
                            OPC_CHUNK: begin
                                chunk_len = w[31:16];
                                passes    = w[15:8];
                                run_left  = COUNT_W'(w[31:16]);
                                if (chunk_len == 0) begin
                                    mode = M_IDLE;
                                end else if (passes >= 2 && chunk_len > HIST_DEPTH) begin
                                    st   = ST_CHUNK;
                                    mode = M_SKIP;
                                end else if (passes == 0) begin
                                    mode = M_SKIP;
                                end else begin
                                    mode = M_CHUNK;
                                end
                            end
                            OPC_COPY: begin
                                if (w[19:8] == 0 || w[19:8] > pix_out) begin
                                    st = ST_OFFSET;
                                end else if (w[31:20] != 0) begin
                                    back_off = w[19:8];
                                    run_left = COUNT_W'(w[31:20]);
                                    mode     = M_COPY;
                                end
                            end
                            default: ;
                        endcase
                    end
                    M_LIT: begin
                        valid    = put_pixel(w);
                        px       = w;
                        run_left = run_left - 1'b1;
                        if (run_left == 0)
                            mode = M_IDLE;
                    end
                    M_FILLWAIT: begin
                        fill_word = w;
                        mode = (run_left != 0) ? M_FILL : M_IDLE;
                    end
                    M_FILL: begin
                        valid    = put_pixel(fill_word);
                        px       = fill_word;
                        run_left = run_left - 1'b1;
                        if (run_left == 0)
                            mode = M_IDLE;
                    end
                    M_CHUNK: begin
                        valid    = put_pixel(w);
                        px       = w;
                        run_left = run_left - 1'b1;
                        if (run_left == 0) begin
                            if (passes >= 2) begin
                                back_off = chunk_len[HIST_AW-1:0];
                                run_left = (passes - 1'b1) * chunk_len;
                                mode     = M_COPY;
                            end else begin
                                mode = M_IDLE;
                            end
                        end
                    end
                    M_COPY: begin
                        idx      = hist_ptr - back_off;
                        px       = history[idx];
                        valid    = put_pixel(px);
                        run_left = run_left - 1'b1;
                        if (run_left == 0)
                            mode = M_IDLE;
                    end
                    default: begin
                        if (run_left != 0)
                            run_left = run_left - 1'b1;
                        if (run_left == 0)
                            mode = M_IDLE;
                    end
                endcase
            end
        end
        r.pixel_valid = valid;
        r.pixel       = valid ? px : '0;
        r.need_word   = frame_full() || wants_word(mode);
        r.frame_done  = frame_full();
        r.status      = st;
        return r;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            mode       = M_IDLE;
            run_left   = '0;
            passes     = '0;
            chunk_len  = '0;
            back_off   = '0;
            fill_word  = '0;
            hist_ptr   = '0;
            pix_out    = '0;
            frame_size = '0;
            pixel_words_due.delete();
            o_errors      = 0;
            o_checked     = 0;
            o_pixels_seen = 0;
            o_flagged     = 0;
        end else begin
            if (i_pop && !i_empty) begin
                if (pixel_words_due.size() == 0) begin
                    $error("result popped with none expected: pixel %h status %0d",
                           i_pixel, i_status);
                    o_errors++;
                end else begin
                    want = pixel_words_due.pop_front();
                    o_checked++;
                    if (i_pixel_valid)
                        o_pixels_seen++;
                    if (i_pixel_valid !== want.pixel_valid) begin
                        $error("pixel_valid: expected %0b, got %0b", want.pixel_valid,
                               i_pixel_valid);
                        o_errors++;
                    end
                    if (i_pixel !== want.pixel) begin
                        $error("pixel: expected %h, got %h", want.pixel, i_pixel);
                        o_errors++;
                    end
                    if (i_need_word !== want.need_word) begin
                        $error("need_word: expected %0b, got %0b", want.need_word, i_need_word);
                        o_errors++;
                    end
                    if (i_frame_done !== want.frame_done) begin
                        $error("frame_done: expected %0b, got %0b", want.frame_done,
                               i_frame_done);
                        o_errors++;
                    end
                    if (i_status !== want.status) begin
                        $error("status: expected %0d, got %0d", want.status, i_status);
                        o_errors++;
                    end
                end
            end
            if (i_total_pixels_we)
                frame_size = i_total_pixels;
            if (i_push && !i_full) begin
                got = decompress_step(i_req_type, i_stream_word);
                if (got.status != ST_OK)
                    o_flagged++;
                pixel_words_due.push_back(got);
            end
        end
        o_pending    = pixel_words_due.size();
        o_pixels_out = pix_out;
    end

endmodule

FILE: sim/word_run_and_backref_decompressor_tb.sv
`timescale 1ns / 1ps
// Testbench top for the decompressor: drives stream words, output ticks and the frame
// size register with random gaps and pops results with random stalls; the checking is
// done by wrbd_pixel_checker. Depends on wrbd_pkg and the decompressor RTL.
module word_run_and_backref_decompressor_tb;
    import wrbd_pkg::*;

    localparam logic KIND_WORD   = 1'b0;
    localparam logic KIND_TICK   = 1'b1;
    localparam int   QUIET_LIMIT = 2000;
    localparam int   RANDOM_ITEMS = 640;

    logic              clk = 1'b0;
    logic              rst_n;
    logic              push;
    logic              full;
    logic              req_tick;
    logic [WORD_W-1:0] stream_word;
    logic              empty;
    logic              pop;
    logic              px_valid;
    logic [WORD_W-1:0] px;
    logic              need_word;
    logic              frame_done;
    logic [1:0]        status;
    logic              tp_we;
    logic [PIX_W-1:0]  tp_value;

    int                n_errors;
    int                n_pending;
    logic [PIX_W-1:0]  pixels_out;
    int                n_checked;
    int                n_pixels;
    int                n_flagged;

    logic              send_fast;
    logic              noise_on;
    int                seq_items;
    int                quiet_cycles = 0;

    always #6 clk = ~clk;

    word_run_and_backref_decompressor u_dut (
        .i_clk             (clk),
        .i_rst_n           (rst_n),
        .push              (push),
        .full              (full),
        .i_req_type        (req_tick),
        .i_stream_word     (stream_word),
        .empty             (empty),
        .pop               (pop),
        .o_pixel_valid     (px_valid),
        .o_pixel           (px),
        .o_need_word       (need_word),
        .o_frame_done      (frame_done),
        .o_status          (status),
        .i_total_pixels_we (tp_we),
        .i_total_pixels    (tp_value)
    );

    wrbd_pixel_checker u_checker (
        .i_clk             (clk),
        .i_rst_n           (rst_n),
        .i_push            (push),
        .i_full            (full),
        .i_req_type        (req_tick),
        .i_stream_word     (stream_word),
        .i_empty           (empty),
        .i_pop             (pop),
        .i_pixel_valid     (px_valid),
        .i_pixel           (px),
        .i_need_word       (need_word),
        .i_frame_done      (frame_done),
        .i_status          (status),
        .i_total_pixels_we (tp_we),
        .i_total_pixels    (tp_value),
        .o_errors          (n_errors),
        .o_pending         (n_pending),
        .o_pixels_out      (pixels_out),
        .o_checked         (n_checked),
        .o_pixels_seen     (n_pixels),
        .o_flagged         (n_flagged)
    );

    function automatic int draw_gap(input logic fast);
        return fast ? 0 : int'($urandom_range(0, 13));
    endfunction

    function automatic logic [23:0] pick_len();
        return 24'(($urandom_range(0, 15) == 0) ? $urandom_range(9, 60)
                                                : $urandom_range(1, 8));
    endfunction

    task automatic put_item(input logic kind, input logic [WORD_W-1:0] w);
        int gap;
        gap = draw_gap(send_fast);
        if (gap > 0) begin
            push <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        push        <= 1'b1;
        req_tick    <= kind;
        stream_word <= w;
        @(posedge clk);
        while (full) @(posedge clk);
        @(negedge clk);
    endtask

    task automatic put_word(input logic [WORD_W-1:0] w);
        if (noise_on && $urandom_range(0, 24) == 0)
            put_item(KIND_TICK, $urandom());
        put_item(KIND_WORD, w);
        seq_items++;
    endtask

    task automatic put_tick();
        if (noise_on && $urandom_range(0, 24) == 0)
            put_item(KIND_WORD, $urandom());
        put_item(KIND_TICK, $urandom());
        seq_items++;
    endtask

    task automatic hold_until_drained();
        push <= 1'b0;
        @(negedge clk);
        while (n_pending != 0) @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic set_frame_size(input logic [PIX_W-1:0] n);
        hold_until_drained();
        tp_value <= n;
        tp_we    <= 1'b1;
        @(negedge clk);
        tp_we    <= 1'b0;
    endtask

    task automatic run_literal(input logic [23:0] n);
        put_word({n, OPC_LIT});
        repeat (n) put_word($urandom());
    endtask

    task automatic run_fill(input logic [23:0] n, input logic [WORD_W-1:0] f);
        put_word({n, OPC_FILL});
        put_word(f);
        repeat (n) put_tick();
    endtask

    task automatic run_chunk(input logic [15:0] l, input logic [7:0] p);
        int replays;
        replays = (p >= 2 && l <= HIST_DEPTH) ? (int'(p) - 1) * int'(l) : 0;
        put_word({l, p, OPC_CHUNK});
        repeat (l) put_word($urandom());
        repeat (replays) put_tick();
    endtask

    task automatic run_copy(input logic [11:0] d, input logic [11:0] n);
        logic takes;
        takes = d != 0 && d <= pixels_out && n != 0;
        put_word({n, d, OPC_COPY});
        if (takes)
            repeat (n) put_tick();
    endtask

    initial begin : result_side
        int   stall;
        logic fast;
        pop  = 1'b0;
        fast = 1'b0;
        wait (rst_n === 1'b1);
        @(negedge clk);
        forever begin
            if ($urandom_range(0, 39) == 0)
                fast = !fast;
            stall = draw_gap(fast);
            if (stall > 0) begin
                pop <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            pop <= 1'b1;
            @(posedge clk);
            while (empty) @(posedge clk);
            @(negedge clk);
        end
    end

    always @(posedge clk) begin
        if (!rst_n || (push && !full) || (pop && !empty)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles == QUIET_LIMIT) begin
            $display("watchdog: no word moved for %0d cycles, %0d results outstanding",
                     QUIET_LIMIT, n_pending);
            $display("word_run_and_backref_decompressor_tb: done, errors");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin : stimulus
        int               lim;
        logic [11:0]      d;
        logic [7:0]       op;
        logic [7:0]       p;
        logic [WORD_W-1:0] rnd;
        logic [PIX_W-1:0] base;
        rst_n       = 1'b0;
        push        = 1'b0;
        req_tick    = KIND_WORD;
        stream_word = '0;
        tp_we       = 1'b0;
        tp_value    = '0;
        send_fast   = 1'b0;
        noise_on    = 1'b0;
        seq_items   = 0;
        repeat (10) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // empty frame: everything is absorbed
        set_frame_size('0);
        put_word('1);
        put_tick();
        put_word({24'd3, OPC_LIT});

        set_frame_size(25'd16777216);
        put_tick();
        put_word('0);
        put_word('1);
        put_word({24'd2, OPC_LIT});
        put_word('1);
        put_item(KIND_TICK, '0);
        put_word('0);
        put_word({24'd0, OPC_LIT});
        run_fill(24'd0, 32'h1234_5678);
        put_word({24'd2, OPC_FILL});
        put_word(32'hA5A5_A5A5);
        put_item(KIND_WORD, 32'h5A5A_0F0F);
        put_tick();
        put_tick();
        put_word({12'd1, 12'd0, OPC_COPY});
        put_word({12'd1, 12'd4000, OPC_COPY});
        run_copy(12'd3, 12'd0);
        run_copy(12'd3, 12'd2);
        run_chunk(16'd0, 8'd2);
        run_chunk(16'd1, 8'd0);
        run_chunk(16'd1, 8'd1);
        run_chunk(16'd2, 8'd2);

        noise_on  = 1'b1;
        seq_items = 0;
        while (seq_items < RANDOM_ITEMS) begin
            if ($urandom_range(0, 7) == 0)
                send_fast = !send_fast;
            if ($urandom_range(0, 39) == 0)
                hold_until_drained();
            case ($urandom_range(0, 9))
                0, 1: run_literal(pick_len());
                2, 3: run_fill(($urandom_range(0, 5) == 0) ? 24'd0 : pick_len(), $urandom());
                4, 5: begin
                    if ($urandom_range(0, 9) == 0)
                        run_chunk(16'($urandom_range(1, 2)), 8'd255);
                    else
                        run_chunk(16'($urandom_range(0, 6)), 8'($urandom_range(0, 4)));
                end
                6, 7: begin
                    lim = (pixels_out > 4095) ? 4095 : int'(pixels_out);
                    case ($urandom_range(0, 7))
                        0: d = '0;
                        1: d = (lim < 4095) ? 12'($urandom_range(lim + 1, 4095)) : 12'd4095;
                        default: d = (lim == 0) ? 12'd0 : 12'($urandom_range(1, lim));
                    endcase
                    run_copy(d, 12'($urandom_range(0, 8)));
                end
                8: begin
                    op  = $urandom_range(5, 260) > 255 ? 8'd0 : 8'($urandom_range(5, 255));
                    rnd = $urandom();
                    put_word({rnd[31:8], op});
                end
                default: put_item(KIND_TICK, $urandom());
            endcase
        end

        // frame fills exactly at the end of a literal run, then absorbs
        send_fast = 1'b0;
        hold_until_drained();
        base = pixels_out;
        set_frame_size(base + 25'd20);
        run_literal(24'd20);
        put_word($urandom());
        put_tick();
        put_word({24'hFF_FFFF, OPC_FILL});

        // frame fills in the middle of a literal run; absorbed words leave the run open
        set_frame_size(base + 25'd45);
        put_word({24'd30, OPC_LIT});
        repeat (30) put_word($urandom());
        put_tick();

        // reopen the frame, finish the run, then flag an oversize chunk
        set_frame_size(base + 25'd60);
        repeat (5) put_word($urandom());
        put_word({16'd4097, 8'd255, OPC_CHUNK});
        repeat (4) put_word($urandom());

        push <= 1'b0;
        @(negedge clk);
        while (n_pending != 0) @(negedge clk);
        repeat (8) @(negedge clk);
        $display("covered %0d result words: %0d pixels, %0d flagged items", n_checked,
                 n_pixels, n_flagged);
        $display("frame sizes 0, 16777216 and short frames filled at and inside a run");
        if (n_errors == 0 && n_pending == 0)
            $display("word_run_and_backref_decompressor_tb: done, clean");
        else
            $display("word_run_and_backref_decompressor_tb: done, errors");
        $finish;
    end

endmodule
